// ===== hdl/tle_pkg.sv =====
// Shared types and constants for the terminal line editor.
// Used by the front classifier, the command queue and the back sequencer.
package tle_pkg;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    // Configuration register indexes
    localparam logic CFG_MAX_LENGTH = 1'b0;
    localparam logic CFG_ECHO_MODE  = 1'b1;

    // Echo modes
    localparam logic [1:0] ECHO_CHAR = 2'd0;
    localparam logic [1:0] ECHO_STAR = 2'd1;

    // Widths of the configuration registers and of a line position
    localparam int MAXLEN_W = 6;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 5;

    // Command queue depth
    localparam int QDEPTH = 4;

    typedef enum logic [1:0] {
        CMD_CHAR  = 2'd0,
        CMD_BS    = 2'd1,
        CMD_ENTER = 2'd2
    } cmd_kind_t;

    // One command from front to back
    typedef struct packed {
        cmd_kind_t        kind;
        logic             echo_en;   // emit an echo for a character or backspace command
        logic             echo_star; // echo '*' in place of the character
        logic [7:0]       data;      // received character
        logic [POS_W-1:0] pos;       // store slot, or line length on enter
    } tle_cmd_t;

endpackage

// ===== hdl/tle_front.sv =====
// Front classifier: accepts received bytes, tracks the line index and
// issues edit commands. Depends on tle_pkg.
module tle_front
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,
    input  logic [MAXLEN_W-1:0] max_length,
    input  logic [MODE_W-1:0]   echo_mode,
    input  logic                q_full,
    output logic                push,
    output tle_cmd_t            cmd
);

    localparam int IW = $clog2(LINE_CAPACITY);
    localparam logic [POS_W-1:0] CAP_LIM = POS_W'(LINE_CAPACITY - 1);

    logic [IW-1:0]    widx_reg, widx_next;
    logic [POS_W-1:0] lim_raw, lim, widx_ext;
    logic             accept, silent;
    logic             is_enter, is_bs, is_print;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign silent   = (echo_mode != ECHO_CHAR) && (echo_mode != ECHO_STAR);
    assign widx_ext = POS_W'(widx_reg);

    // Character limit from the buffer size, clipped to the store
    assign lim_raw = (max_length == '0) ? '0 : POS_W'(max_length - MAXLEN_W'(1));
    assign lim     = (lim_raw > CAP_LIM) ? CAP_LIM : lim_raw;

    assign is_enter = (s_tdata == CH_CR) || (s_tdata == CH_LF);
    assign is_bs    = (s_tdata == CH_BS) || (s_tdata == CH_DEL);
    assign is_print = (s_tdata >= CH_SPACE) && (s_tdata <= CH_TILDE);

    // Classify the byte and build the command
    always_comb begin
        widx_next     = widx_reg;
        push          = 1'b0;
        cmd.kind      = CMD_CHAR;
        cmd.echo_en   = 1'b0;
        cmd.echo_star = (echo_mode == ECHO_STAR);
        cmd.data      = s_tdata;
        cmd.pos       = widx_ext;
        if (accept) begin
            priority if (is_enter) begin
                cmd.kind  = CMD_ENTER;
                push      = 1'b1;
                widx_next = '0;
            end else if (is_bs) begin
                if (widx_reg != '0) begin
                    cmd.kind    = CMD_BS;
                    cmd.echo_en = !silent;
                    push        = !silent;
                    widx_next   = widx_reg - IW'(1);
                end
            end else if (is_print && (widx_ext < lim)) begin
                cmd.kind    = CMD_CHAR;
                cmd.echo_en = !silent;
                push        = 1'b1;
                widx_next   = widx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg <= '0;
        end else begin
            widx_reg <= widx_next;
        end
    end

endmodule

// ===== hdl/tle_queue.sv =====
// Short first-word-fall-through queue of edit commands between front
// and back. Depends on tle_pkg.
module tle_queue
    import tle_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  tle_cmd_t push_cmd,
    input  logic     pop,
    output tle_cmd_t head,
    output logic     full,
    output logic     empty
);

    localparam int PW = $clog2(QDEPTH);

    tle_cmd_t        slots_reg [QDEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [PW:0]     count_reg;

    assign full  = (count_reg == (PW + 1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rptr_reg];

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW + 1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW + 1)'(1);
            end
        end
    end

endmodule

// ===== hdl/tle_back.sv =====
// Back sequencer: executes edit commands, owns the line store and drives
// the registered result channel. Depends on tle_pkg.
module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tle_cmd_t         head,
    input  logic             q_empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       out_byte,
    output logic             to_terminal,
    output logic             line_done,
    output logic [LEN_W-1:0] line_length,
    output logic             out_last
);

    localparam int IW = $clog2(LINE_CAPACITY);

    typedef enum logic [3:0] {
        B_IDLE, B_CHAR, B_BS1, B_BS2, B_BS3, B_CR, B_LF, B_RD, B_LN
    } state_t;

    state_t           state_reg;
    tle_cmd_t         cmd_reg;
    logic [IW-1:0]    ptr_reg;
    logic [6:0]       line_mem [LINE_CAPACITY];
    logic [6:0]       rd_data_reg;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             term_reg, done_reg, last_reg;
    logic [LEN_W-1:0] len_reg;
    logic             slot_free;
    logic [IW-1:0]    len_iw;

    assign pop       = (state_reg == B_IDLE) && !q_empty;
    assign slot_free = !out_valid_reg || m_tready;
    assign len_iw    = cmd_reg.pos[IW-1:0];

    assign m_tvalid    = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign to_terminal = term_reg;
    assign line_done   = done_reg;
    assign line_length = len_reg;
    assign out_last    = last_reg;

    // Line store: write on a character command, read during the dump
    always_ff @(posedge aclk) begin
        if (pop && (head.kind == CMD_CHAR)) begin
            line_mem[head.pos[IW-1:0]] <= head.data[6:0];
        end
        if (state_reg == B_RD) begin
            rd_data_reg <= line_mem[ptr_reg];
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
        end else begin
            if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (pop) begin
                        cmd_reg <= head;
                        unique case (head.kind)
                            CMD_CHAR:  state_reg <= head.echo_en ? B_CHAR : B_IDLE;
                            CMD_BS:    state_reg <= head.echo_en ? B_BS1 : B_IDLE;
                            CMD_ENTER: state_reg <= B_CR;
                            default:   state_reg <= B_IDLE;
                        endcase
                    end
                end
                B_CHAR, B_BS1, B_BS2, B_BS3, B_CR: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        term_reg      <= 1'b1;
                        done_reg      <= 1'b0;
                        len_reg       <= '0;
                        last_reg      <= 1'b0;
                        unique case (state_reg)
                            B_CHAR: begin
                                out_byte_reg <= cmd_reg.echo_star ? CH_STAR : cmd_reg.data;
                                last_reg     <= 1'b1;
                                state_reg    <= B_IDLE;
                            end
                            B_BS1: begin
                                out_byte_reg <= CH_BS;
                                state_reg    <= B_BS2;
                            end
                            B_BS2: begin
                                out_byte_reg <= CH_SPACE;
                                state_reg    <= B_BS3;
                            end
                            B_BS3: begin
                                out_byte_reg <= CH_BS;
                                last_reg     <= 1'b1;
                                state_reg    <= B_IDLE;
                            end
                            default: begin
                                out_byte_reg <= CH_CR;
                                state_reg    <= B_LF;
                            end
                        endcase
                    end
                end
                B_LF: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= CH_LF;
                        term_reg      <= 1'b1;
                        len_reg       <= '0;
                        ptr_reg       <= '0;
                        // Empty line ends on the LF
                        if (cmd_reg.pos == '0) begin
                            done_reg  <= 1'b1;
                            last_reg  <= 1'b1;
                            state_reg <= B_IDLE;
                        end else begin
                            done_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            state_reg <= B_RD;
                        end
                    end
                end
                B_RD: begin
                    state_reg <= B_LN;
                end
                B_LN: begin
                    if (slot_free) begin
                        out_valid_reg <= 1'b1;
                        out_byte_reg  <= {1'b0, rd_data_reg};
                        term_reg      <= 1'b0;
                        if (ptr_reg == len_iw - IW'(1)) begin
                            done_reg  <= 1'b1;
                            last_reg  <= 1'b1;
                            len_reg   <= cmd_reg.pos[LEN_W-1:0];
                            state_reg <= B_IDLE;
                        end else begin
                            done_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                            len_reg   <= '0;
                            ptr_reg   <= ptr_reg + IW'(1);
                            state_reg <= B_RD;
                        end
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/terminal_line_editor_core.sv =====
// Top level of the terminal line editor: configuration registers, front
// classifier, command queue and back sequencer. Depends on tle_pkg.
//
//  channel  | direction | transfer                | payload
//  ---------+-----------+-------------------------+-------------------------------
//  s_       | in        | s_tvalid && s_tready    | tdata: rx_byte
//  m_       | out       | m_tvalid && m_tready    | tdata/tuser/tlast, see ports
//  cfg_     | in        | cfg_we                  | cfg_index, cfg_wdata
//
// A byte is classified in the cycle it is taken; the back sequencer pops
// a command, then loads each echo byte, and on enter loads CR and LF and
// then, for each stored character, reads the store and loads the output
// (a full line has 31 characters). The four-entry command queue sets how
// far the input runs ahead. Reset clears the line index, queue and output
// register; the line store needs no clearing. A stalled result holds in
// the output register while the front keeps taking bytes until the queue
// fills.
module terminal_line_editor_core
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [7:0] out_byte, [8] line_done,
                                           // [13:9] line_length, [15:14] zero
    output logic                m_tuser,   // [0] to_terminal
    output logic                m_tlast,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [MAXLEN_W-1:0] cfg_wdata
);

    logic [MAXLEN_W-1:0] max_length_reg;
    logic [MODE_W-1:0]   echo_mode_reg;
    logic                push, pop, q_full, q_empty;
    tle_cmd_t            push_cmd, head;
    logic [7:0]          out_byte;
    logic                line_done;
    logic [LEN_W-1:0]    line_length;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg <= MAXLEN_W'(32);
            echo_mode_reg  <= ECHO_CHAR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_LENGTH: max_length_reg <= cfg_wdata;
                CFG_ECHO_MODE:  echo_mode_reg  <= cfg_wdata[MODE_W-1:0];
                default:        ;
            endcase
        end
    end

    tle_front #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .max_length (max_length_reg),
        .echo_mode  (echo_mode_reg),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    tle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tle_back #(
        .LINE_CAPACITY(LINE_CAPACITY)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (head),
        .q_empty     (q_empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .out_byte    (out_byte),
        .to_terminal (m_tuser),
        .line_done   (line_done),
        .line_length (line_length),
        .out_last    (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {2'b00, line_length, line_done, out_byte};

endmodule

// ===== hdl/tle_checker.sv =====
// Port-level checks for the terminal line editor, bound to the top level.
// Depends on tle_pkg.
module tle_checker
    import tle_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Line done always closes the run of one input byte
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tlast)
        else $error("line done without last");

    // A line character is last exactly when it closes the line
    a_line_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tlast == m_tdata[8]))
        else $error("line character last mismatch");

    // Line characters are printable
    a_printable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[7:0] >= CH_SPACE) && (m_tdata[7:0] <= CH_TILDE))
        else $error("line character not printable");

    // Length is zero except on line done
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[8] |-> (m_tdata[13:9] == 5'd0))
        else $error("line length outside line done");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
